// ----- hw/rtl/ssfd_pkg.sv -----
// ============================================================================
// ssfd_pkg
// Shared widths, register codes and word types of the soft selection
// falloff displacement block.
// ============================================================================
package ssfd_pkg;

    localparam int C_IDX_W     = 12;
    localparam int C_COORD_W   = 32;
    localparam int C_RAD_W     = 31;
    localparam int C_ROOT_W    = 32;
    localparam int C_FRAC_W    = 32;
    localparam int C_CFG_IDX_W = 3;

    // Vertices with an index at or above this pass unchanged.
    localparam logic [16:0] C_MAX_VERTICES = 17'd4096;

    // ceil(2^34 / 5): floor(t / 5) == (t * C_RECIP5) >> 34 for any 32-bit t.
    localparam logic [31:0] C_RECIP5 = 32'hCCCC_CCCD;

    // 1.0 in Q1.31, the largest falloff fraction.
    localparam logic [C_FRAC_W-1:0] C_ONE_Q31 = 32'h8000_0000;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_SHIFT_X  = 3'd2,
        CFG_SHIFT_Y  = 3'd3,
        CFG_RADIUS   = 3'd4
    } t_cfg_idx;

    // Data that rides alongside the arithmetic through every stage.
    typedef struct packed {
        logic [C_IDX_W-1:0]   idx;
        logic [C_COORD_W-1:0] vx;
        logic [C_COORD_W-1:0] vy;
        logic                 flag;
    } t_side;

    typedef struct packed {
        logic [C_IDX_W-1:0]   out_index;
        logic [C_COORD_W-1:0] new_x;
        logic [C_COORD_W-1:0] new_y;
        logic                 moved;
    } t_res;

endpackage

// ----- hw/rtl/ssfd_ifs.sv -----
// ============================================================================
// ssfd interfaces
// Valid/ready channels of the soft selection block: vertex words in,
// result words out, and configuration register writes.
// ============================================================================
interface ssfd_vtx_if import ssfd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic        [C_IDX_W-1:0]   vertex_index;
    logic signed [C_COORD_W-1:0] vertex_x;
    logic signed [C_COORD_W-1:0] vertex_y;

    modport source (output valid, vertex_index, vertex_x, vertex_y, input ready);
    modport sink   (input valid, vertex_index, vertex_x, vertex_y, output ready);
endinterface

interface ssfd_res_if import ssfd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic        [C_IDX_W-1:0]   out_index;
    logic signed [C_COORD_W-1:0] new_x;
    logic signed [C_COORD_W-1:0] new_y;
    logic                        moved;

    modport source (output valid, out_index, new_x, new_y, moved, input ready);
    modport sink   (input valid, out_index, new_x, new_y, moved, output ready);
endinterface

interface ssfd_cfg_if import ssfd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [C_CFG_IDX_W-1:0] index;
    logic [C_COORD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ssfd_isqrt.sv -----
// ============================================================================
// ssfd_isqrt
// Pipelined integer square root: one root bit per stage, the remainder and
// partial root carried forward, so a new radicand may enter every cycle with i_en high.
// ============================================================================
module ssfd_isqrt import ssfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  logic [2*C_ROOT_W-1:0] i_radicand,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [C_ROOT_W-1:0]   o_root
);

    localparam int STAGES = C_ROOT_W;
    localparam int RAD_W  = 2 * C_ROOT_W;
    localparam int REM_W  = C_ROOT_W + 2;
    localparam int CUR_W  = REM_W + 2;

    logic                r_v    [STAGES];
    t_side               r_side [STAGES];
    logic [RAD_W-1:0]    r_rad  [STAGES];
    logic [REM_W-1:0]    r_rem  [STAGES];
    logic [C_ROOT_W-1:0] r_root [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                w_v_in;
        t_side               w_side_in;
        logic [RAD_W-1:0]    w_rad_in;
        logic [REM_W-1:0]    w_rem_in;
        logic [C_ROOT_W-1:0] w_root_in;
        logic [CUR_W-1:0]    w_cur;
        logic [CUR_W-1:0]    w_trial;
        logic                w_ge;

        if (g == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
            assign w_rad_in  = i_radicand;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_v_in    = r_v[g-1];
            assign w_side_in = r_side[g-1];
            assign w_rad_in  = r_rad[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
        end

        // Bring down the next pair of radicand bits and try 4*root + 1.
        assign w_cur   = {w_rem_in, w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_side_in;
                r_rad[g]  <= {w_rad_in[RAD_W-3:0], 2'b00};
                r_rem[g]  <= w_ge ? REM_W'(w_cur - w_trial) : w_cur[REM_W-1:0];
                r_root[g] <= {w_root_in[C_ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_root  = r_root[STAGES-1];

endmodule

// ----- hw/rtl/ssfd_div.sv -----
// ============================================================================
// ssfd_div
// Pipelined restoring divider for the falloff fraction: num * 2^31 / den
// with num <= den, one quotient bit per stage, most significant first.
// ============================================================================
module ssfd_div import ssfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_side               i_side,
    input  logic [C_RAD_W-1:0]  i_num,
    input  logic [C_RAD_W-1:0]  i_den,
    output logic                o_valid,
    output t_side               o_side,
    output logic [C_FRAC_W-1:0] o_quot
);

    localparam int STAGES = C_FRAC_W;
    localparam int CUR_W  = C_RAD_W + 1;

    logic                r_v    [STAGES];
    t_side               r_side [STAGES];
    logic [C_RAD_W-1:0]  r_rem  [STAGES];
    logic [C_FRAC_W-1:0] r_quot [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                w_v_in;
        t_side               w_side_in;
        logic [C_FRAC_W-1:0] w_quot_in;
        logic [CUR_W-1:0]    w_cur;
        logic                w_ge;

        // The first stage yields the integer bit, the rest shift the
        // remainder up by one before each trial subtraction.
        if (g == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
            assign w_quot_in = '0;
            assign w_cur     = {1'b0, i_num};
        end else begin : g_next
            assign w_v_in    = r_v[g-1];
            assign w_side_in = r_side[g-1];
            assign w_quot_in = r_quot[g-1];
            assign w_cur     = {r_rem[g-1], 1'b0};
        end

        assign w_ge = (w_cur >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_side_in;
                r_rem[g]  <= w_ge ? C_RAD_W'(w_cur - {1'b0, i_den}) : w_cur[C_RAD_W-1:0];
                r_quot[g] <= {w_quot_in[C_FRAC_W-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_quot  = r_quot[STAGES-1];

endmodule

// ----- hw/rtl/soft_selection_falloff_displace.sv -----
// ============================================================================
// soft_selection_falloff_displace
// Moves mesh vertices lying within a radius of a centre by a quadratic
// falloff of a configured shift, one vertex word per cycle unless stalled.
// ============================================================================
//
//  channel  | dir | payload                               | accepted when
//  ---------+-----+---------------------------------------+-----------------
//  i_vtx    | in  | vertex_index, vertex_x, vertex_y      | valid && ready
//  o_res    | out | out_index, new_x, new_y, moved        | valid && ready
//  i_cfg    | in  | index (0..4 registers), data          | valid (ready = 1)
//
//  One vertex word is taken every cycle while the skid register is empty;
//  the pipeline holds the 32-stage square root and the 32-stage divider,
//  each producing one bit per stage, plus eight arithmetic stages and the
//  output register, the first loading on the edge that accepts the word.
//  Reset is synchronous and active low; it clears all valid bits and loads
//  the register defaults (radius 0.5, everything else zero).
//  A stalled output word is held while a skid register takes the next one;
//  the whole pipeline then freezes until the skid register drains.
//
module soft_selection_falloff_displace import ssfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssfd_vtx_if.sink          i_vtx,
    ssfd_res_if.source        o_res,
    ssfd_cfg_if.sink          i_cfg
);

    // ---------------------------------------------------------------- config
    logic [C_COORD_W-1:0] r_center_x;
    logic [C_COORD_W-1:0] r_center_y;
    logic [C_COORD_W-1:0] r_mag_x;
    logic [C_COORD_W-1:0] r_mag_y;
    logic                 r_neg_x;
    logic                 r_neg_y;
    logic [C_RAD_W-1:0]   r_radius;
    logic [C_COORD_W-1:0] w_cfg_mag;

    assign i_cfg.ready = 1'b1;
    // Shifts are kept as sign and magnitude for the unsigned multipliers.
    assign w_cfg_mag = i_cfg.data[C_COORD_W-1] ? (~i_cfg.data + 32'd1) : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_mag_x    <= '0;
            r_mag_y    <= '0;
            r_neg_x    <= 1'b0;
            r_neg_y    <= 1'b0;
            r_radius   <= 31'd32768;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CENTER_X: r_center_x <= i_cfg.data;
                CFG_CENTER_Y: r_center_y <= i_cfg.data;
                CFG_SHIFT_X: begin
                    r_neg_x <= i_cfg.data[C_COORD_W-1];
                    r_mag_x <= w_cfg_mag;
                end
                CFG_SHIFT_Y: begin
                    r_neg_y <= i_cfg.data[C_COORD_W-1];
                    r_mag_y <= w_cfg_mag;
                end
                CFG_RADIUS: r_radius <= i_cfg.data[C_RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    logic w_en;
    logic r_out_v;
    logic r_skid_v;
    t_res r_out;
    t_res r_skid;

    assign w_en        = !r_skid_v;
    assign i_vtx.ready = w_en;

    // ---------------------------------------------------------------- stage 1
    logic [C_COORD_W:0]   w_dx;
    logic [C_COORD_W:0]   w_dy;
    logic [C_COORD_W-1:0] w_adx;
    logic [C_COORD_W-1:0] w_ady;
    logic                 w_elig;
    t_side                w_in_side;

    logic                 r_v1;
    t_side                r_s1_side;
    logic [C_RAD_W-1:0]   r_s1_adx;
    logic [C_RAD_W-1:0]   r_s1_ady;

    assign w_dx  = {i_vtx.vertex_x[C_COORD_W-1], i_vtx.vertex_x}
                 - {r_center_x[C_COORD_W-1], r_center_x};
    assign w_dy  = {i_vtx.vertex_y[C_COORD_W-1], i_vtx.vertex_y}
                 - {r_center_y[C_COORD_W-1], r_center_y};
    assign w_adx = w_dx[C_COORD_W] ? C_COORD_W'(~w_dx + 33'd1) : w_dx[C_COORD_W-1:0];
    assign w_ady = w_dy[C_COORD_W] ? C_COORD_W'(~w_dy + 33'd1) : w_dy[C_COORD_W-1:0];

    // A far offset on either axis settles the case before any squaring.
    assign w_elig = ({5'b0, i_vtx.vertex_index} < C_MAX_VERTICES)
                 && (w_adx < {1'b0, r_radius}) && (w_ady < {1'b0, r_radius});

    always_comb begin
        w_in_side.idx  = i_vtx.vertex_index;
        w_in_side.vx   = i_vtx.vertex_x;
        w_in_side.vy   = i_vtx.vertex_y;
        w_in_side.flag = w_elig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= w_in_side;
            r_s1_adx  <= w_elig ? w_adx[C_RAD_W-1:0] : '0;
            r_s1_ady  <= w_elig ? w_ady[C_RAD_W-1:0] : '0;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic                   r_v2;
    t_side                  r_s2_side;
    logic [2*C_RAD_W-1:0]   r_s2_sqx;
    logic [2*C_RAD_W-1:0]   r_s2_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side <= r_s1_side;
            r_s2_sqx  <= r_s1_adx * r_s1_adx;
            r_s2_sqy  <= r_s1_ady * r_s1_ady;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic                  r_v3;
    t_side                 r_s3_side;
    logic [2*C_RAD_W:0]    r_s3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_side <= r_s2_side;
            r_s3_sum  <= {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        end
    end

    // ---------------------------------------------------------------- root
    logic                w_sq_v;
    t_side               w_sq_side;
    logic [C_ROOT_W-1:0] w_sq_root;

    ssfd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v3),
        .i_side     (r_s3_side),
        .i_radicand ({1'b0, r_s3_sum}),
        .o_valid    (w_sq_v),
        .o_side     (w_sq_side),
        .o_root     (w_sq_root)
    );

    // ---------------------------------------------------------------- stage 4
    logic               w_inside;
    t_side              w_s4_side;
    logic               r_v4;
    t_side              r_s4_side;
    logic [C_RAD_W-1:0] r_s4_num;

    assign w_inside = w_sq_side.flag && (w_sq_root < {1'b0, r_radius});

    always_comb begin
        w_s4_side      = w_sq_side;
        w_s4_side.flag = w_inside;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side <= w_s4_side;
            r_s4_num  <= w_inside ? (r_radius - w_sq_root[C_RAD_W-1:0]) : '0;
        end
    end

    // ---------------------------------------------------------------- divide
    logic                w_dv_v;
    t_side               w_dv_side;
    logic [C_FRAC_W-1:0] w_dv_q;

    ssfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_side  (r_s4_side),
        .i_num   (r_s4_num),
        .i_den   (r_radius),
        .o_valid (w_dv_v),
        .o_side  (w_dv_side),
        .o_quot  (w_dv_q)
    );

    // ---------------------------------------------------------------- stage 5
    logic [2*C_FRAC_W-1:0] w_psq;
    logic                  r_v5;
    t_side                 r_s5_side;
    logic [C_FRAC_W-1:0]   r_s5_w;

    // Squared fraction back in Q1.31; at most 1.0, so bit 63 is always clear.
    assign w_psq = w_dv_q * w_dv_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side <= w_dv_side;
            r_s5_w    <= w_psq[2*C_FRAC_W-2:C_FRAC_W-1];
        end
    end

    // ---------------------------------------------------------------- stage 6
    logic [2*C_FRAC_W-1:0] w_tx;
    logic [2*C_FRAC_W-1:0] w_ty;
    logic                  r_v6;
    t_side                 r_s6_side;
    logic [C_COORD_W-1:0]  r_s6_tx;
    logic [C_COORD_W-1:0]  r_s6_ty;

    assign w_tx = r_s5_w * r_mag_x;
    assign w_ty = r_s5_w * r_mag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_side <= r_s5_side;
            r_s6_tx   <= w_tx[2*C_FRAC_W-2:C_FRAC_W-1];
            r_s6_ty   <= w_ty[2*C_FRAC_W-2:C_FRAC_W-1];
        end
    end

    // ---------------------------------------------------------------- stage 7
    logic [2*C_COORD_W-1:0] w_qx;
    logic [2*C_COORD_W-1:0] w_qy;
    logic                   r_v7;
    t_side                  r_s7_side;
    logic [29:0]            r_s7_dmx;
    logic [29:0]            r_s7_dmy;

    // The divide by five as a reciprocal multiply; exact for 32-bit values.
    assign w_qx = r_s6_tx * C_RECIP5;
    assign w_qy = r_s6_ty * C_RECIP5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_side <= r_s6_side;
            r_s7_dmx  <= w_qx[63:34];
            r_s7_dmy  <= w_qy[63:34];
        end
    end

    // ---------------------------------------------------------------- stage 8
    function automatic logic [C_COORD_W-1:0] sat_move(
        input logic [C_COORD_W-1:0] v,
        input logic [29:0]          dm,
        input logic                 neg
    );
        logic [C_COORD_W+1:0] ext;
        logic [C_COORD_W+1:0] off;
        logic [C_COORD_W+1:0] sum;
        logic [C_COORD_W-1:0] res;
        ext = {{2{v[C_COORD_W-1]}}, v};
        off = {4'b0, dm};
        sum = neg ? (ext - off) : (ext + off);
        if (!sum[C_COORD_W+1] && (sum[C_COORD_W:C_COORD_W-1] != 2'b00)) begin
            res = 32'h7FFF_FFFF;
        end else if (sum[C_COORD_W+1] && (sum[C_COORD_W:C_COORD_W-1] != 2'b11)) begin
            res = 32'h8000_0000;
        end else begin
            res = sum[C_COORD_W-1:0];
        end
        return res;
    endfunction

    t_res w_s8_res;
    logic r_v8;
    t_res r_s8_res;

    always_comb begin
        w_s8_res.out_index = r_s7_side.idx;
        w_s8_res.moved     = r_s7_side.flag;
        if (r_s7_side.flag) begin
            w_s8_res.new_x = sat_move(r_s7_side.vx, r_s7_dmx, r_neg_x);
            w_s8_res.new_y = sat_move(r_s7_side.vy, r_s7_dmy, r_neg_y);
        end else begin
            w_s8_res.new_x = r_s7_side.vx;
            w_s8_res.new_y = r_s7_side.vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_res <= w_s8_res;
        end
    end

    // ---------------------------------------------------------------- output
    logic w_take;
    logic w_pipe_out;
    logic n_out_v;
    logic n_skid_v;

    assign w_take     = r_out_v && o_res.ready;
    assign w_pipe_out = w_en && r_v8;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            if (w_take) begin
                n_skid_v = 1'b0;
            end
        end else if (w_pipe_out) begin
            if (!r_out_v || w_take) begin
                n_out_v = 1'b1;
            end else begin
                n_skid_v = 1'b1;
            end
        end else if (w_take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_pipe_out) begin
            if (!r_out_v || w_take) begin
                r_out <= r_s8_res;
            end else begin
                r_skid <= r_s8_res;
            end
        end
    end

    assign o_res.valid     = r_out_v;
    assign o_res.out_index = r_out.out_index;
    assign o_res.new_x     = r_out.new_x;
    assign o_res.new_y     = r_out.new_y;
    assign o_res.moved     = r_out.moved;

    // ---------------------------------------------------------------- checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a word while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_res.ready))
        else $error("skid register filled without an output stall");

    a_inside_numerator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_s4_side.flag) |-> (r_s4_num != '0))
        else $error("vertex inside the radius with a zero falloff numerator");

    a_fraction_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv_v && w_dv_side.flag) |-> (w_dv_q <= C_ONE_Q31))
        else $error("falloff fraction exceeds one");

endmodule
